### rtl/core/rnot_pkg.sv
// Shared types, constants and codes for the ReLU neuron online trainer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package rnot_pkg;

	// Number of weights held by the neuron
	localparam int FEATURES = 2;
	localparam int IDX_W    = (FEATURES > 1) ? $clog2(FEATURES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FEATURES - 1);
	// Position of the second weight (reads as zero when only one weight exists)
	localparam int WB_IDX   = (FEATURES > 1) ? 1 : 0;

	// Configuration port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam logic [15:0] RATE_RESET = 16'd66;

	// Request mode codes
	localparam logic [1:0] MODE_TRAIN  = 2'd1;
	localparam logic [1:0] MODE_RELOAD = 2'd2;

	// Register indexes (byte address 4*index)
	typedef enum logic [1:0] {
		REG_RATE,
		REG_INIT_A,
		REG_INIT_B,
		REG_INIT_BIAS
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] sample_a;
		logic signed [15:0] sample_b;
		logic signed [15:0] goal;
	} req_t;

	typedef struct packed {
		logic [14:0]        prediction;
		logic signed [23:0] weight_a_now;
		logic signed [23:0] weight_b_now;
		logic signed [23:0] bias_now;
		logic               clipped;
	} rsp_t;

	typedef struct packed {
		logic [15:0]        learn_rate;
		logic signed [23:0] init_weight_a;
		logic signed [23:0] init_weight_b;
		logic signed [23:0] init_bias;
	} cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic             load;
		logic             dot_mul;
		logic             acc_add;
		logic             rnd;
		logic             rate_mul;
		logic             bias_upd;
		logic             upd_mul;
		logic             upd_add;
		logic             out_load;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic train;
	} sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DOT,
		ST_ACC,
		ST_RND,
		ST_RATE,
		ST_BIAS,
		ST_UMUL,
		ST_UADD,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

### rtl/core/rnot_regs.sv
// Configuration register file behind the APB-style port.
// Depends on rnot_pkg for the register codes and the cfg_t bundle.
`default_nettype none

module rnot_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rnot_pkg::ADDR_W-1:0] paddr,
	input  logic [rnot_pkg::DATA_W-1:0] pwdata,
	output logic [rnot_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output rnot_pkg::cfg_t              cfg
);

	rnot_pkg::cfg_t     cfg_q;
	rnot_pkg::reg_idx_t sel;
	logic               wr_en;

	assign sel    = rnot_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.learn_rate    <= rnot_pkg::RATE_RESET;
			cfg_q.init_weight_a <= '0;
			cfg_q.init_weight_b <= '0;
			cfg_q.init_bias     <= '0;
		end else if (wr_en) begin
			case (sel)
				rnot_pkg::REG_RATE:      cfg_q.learn_rate    <= pwdata[15:0];
				rnot_pkg::REG_INIT_A:    cfg_q.init_weight_a <= pwdata[23:0];
				rnot_pkg::REG_INIT_B:    cfg_q.init_weight_b <= pwdata[23:0];
				rnot_pkg::REG_INIT_BIAS: cfg_q.init_bias     <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// Read mux; signed registers come back sign extended
	always_comb begin
		case (sel)
			rnot_pkg::REG_RATE:
				prdata = {16'b0, cfg_q.learn_rate};
			rnot_pkg::REG_INIT_A:
				prdata = {{8{cfg_q.init_weight_a[23]}}, cfg_q.init_weight_a};
			rnot_pkg::REG_INIT_B:
				prdata = {{8{cfg_q.init_weight_b[23]}}, cfg_q.init_weight_b};
			rnot_pkg::REG_INIT_BIAS:
				prdata = {{8{cfg_q.init_bias[23]}}, cfg_q.init_bias};
			default:
				prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/rnot_ctrl.sv
// Sequencing state machine for the neuron: steps the shared multiplier
// through dot product, rounding, error scaling and weight updates.
// Depends on rnot_pkg for state, command and status types.
`default_nettype none

module rnot_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  rnot_pkg::sts_t sts,
	output rnot_pkg::cmd_t cmd
);

	rnot_pkg::state_t            state_q;
	rnot_pkg::state_t            state_d;
	logic [rnot_pkg::IDX_W-1:0]  idx_q;
	logic                        rsp_valid_q;
	logic                        idx_last;
	logic                        out_free;

	assign idx_last  = (idx_q == rnot_pkg::LAST_IDX);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == rnot_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rnot_pkg::ST_IDLE: if (req_valid) state_d = rnot_pkg::ST_DOT;
			rnot_pkg::ST_DOT:  if (idx_last) state_d = rnot_pkg::ST_ACC;
			rnot_pkg::ST_ACC:  state_d = rnot_pkg::ST_RND;
			rnot_pkg::ST_RND:  state_d = sts.train ? rnot_pkg::ST_RATE : rnot_pkg::ST_DONE;
			rnot_pkg::ST_RATE: state_d = rnot_pkg::ST_BIAS;
			rnot_pkg::ST_BIAS: state_d = rnot_pkg::ST_UMUL;
			rnot_pkg::ST_UMUL: state_d = rnot_pkg::ST_UADD;
			rnot_pkg::ST_UADD: state_d = idx_last ? rnot_pkg::ST_DONE : rnot_pkg::ST_UMUL;
			rnot_pkg::ST_DONE: if (out_free) state_d = rnot_pkg::ST_IDLE;
			default:           state_d = rnot_pkg::ST_IDLE;
		endcase
	end

	// Command decode
	always_comb begin
		cmd     = '0;
		cmd.idx = idx_q;
		case (state_q)
			rnot_pkg::ST_IDLE: cmd.load = req_valid;
			rnot_pkg::ST_DOT: begin
				cmd.dot_mul = 1'b1;
				cmd.acc_add = (idx_q != '0);
			end
			rnot_pkg::ST_ACC:  cmd.acc_add  = 1'b1;
			rnot_pkg::ST_RND:  cmd.rnd      = 1'b1;
			rnot_pkg::ST_RATE: cmd.rate_mul = 1'b1;
			rnot_pkg::ST_BIAS: cmd.bias_upd = 1'b1;
			rnot_pkg::ST_UMUL: cmd.upd_mul  = 1'b1;
			rnot_pkg::ST_UADD: cmd.upd_add  = 1'b1;
			rnot_pkg::ST_DONE: cmd.out_load = out_free;
			default: ;
		endcase
	end

	// State, feature counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rnot_pkg::ST_IDLE;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// counter wraps after the last weight, ready for the next pass
			if (state_q == rnot_pkg::ST_DOT || state_q == rnot_pkg::ST_UADD) begin
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end else if (state_q == rnot_pkg::ST_IDLE) begin
				idx_q <= '0;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/rnot_dp.sv
// Datapath: weight and bias storage, one shared signed multiplier,
// accumulator, rounding, saturation and the output register.
// Depends on rnot_pkg for payload, config and command types.
`default_nettype none

module rnot_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  rnot_pkg::req_t req_data,
	input  rnot_pkg::cfg_t cfg,
	input  rnot_pkg::cmd_t cmd,
	output rnot_pkg::sts_t sts,
	output rnot_pkg::rsp_t rsp_data
);

	// Saturate a widened sum to the signed 24-bit weight range
	function automatic logic signed [23:0] sat_w(input logic signed [33:0] v);
		logic signed [23:0] r;
		if (v > 34'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -34'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	function automatic logic ovf_w(input logic signed [33:0] v);
		return (v > 34'sd8388607) || (v < -34'sd8388608);
	endfunction

	// Feature by index; weights beyond the second see zero
	function automatic logic signed [15:0] feature(
		input rnot_pkg::req_t           r,
		input logic [rnot_pkg::IDX_W-1:0] i
	);
		logic signed [15:0] f;
		if (i == '0) begin
			f = r.sample_a;
		end else if (i == rnot_pkg::IDX_W'(1)) begin
			f = r.sample_b;
		end else begin
			f = '0;
		end
		return f;
	endfunction

	rnot_pkg::req_t     item_q;
	rnot_pkg::rsp_t     rsp_q;
	logic signed [23:0] weight_q [rnot_pkg::FEATURES];
	logic signed [23:0] bias_q;
	logic signed [41:0] acc_q;
	logic signed [48:0] prod_q;
	logic signed [32:0] re_q;
	logic [14:0]        pred_q;
	logic               clip_q;

	logic signed [15:0] x_sel;
	logic signed [23:0] w_cur;
	logic signed [32:0] mul_a;
	logic signed [23:0] mul_b;
	logic signed [56:0] product;
	logic signed [16:0] err;
	logic signed [41:0] rsum;
	logic signed [25:0] rval;
	logic               pred_neg;
	logic               pred_ovf;
	logic signed [33:0] bias_sum;
	logic signed [33:0] w_sum;

	assign x_sel = feature(item_q, cmd.idx);
	assign w_cur = weight_q[cmd.idx];
	assign err   = {item_q.goal[15], item_q.goal} - {2'b00, pred_q};

	// Shared multiplier operand select
	always_comb begin
		if (cmd.rate_mul) begin
			mul_a = {{16{err[16]}}, err};
			mul_b = {8'b0, cfg.learn_rate};
		end else if (cmd.upd_mul) begin
			mul_a = re_q;
			mul_b = {{8{x_sel[15]}}, x_sel};
		end else begin
			mul_a = {{17{x_sel[15]}}, x_sel};
			mul_b = w_cur;
		end
	end

	assign product = mul_a * mul_b;

	// Prediction: round to nearest (ties up), then ReLU and clamp
	assign rsum     = acc_q + 42'sd32768;
	assign rval     = rsum[41:16];
	assign pred_neg = rval[25];
	assign pred_ovf = !rval[25] && (|rval[24:15]);

	// Bias step: bias + round(rate*err / 2^8)
	assign bias_sum = {{10{bias_q[23]}}, bias_q} + {{9{prod_q[32]}}, prod_q[32:8]}
		+ {33'b0, prod_q[7]};

	// Weight step: w + round(rate*err*x / 2^16)
	assign w_sum = {{10{w_cur[23]}}, w_cur} + {prod_q[48], prod_q[48:16]}
		+ {33'b0, prod_q[15]};

	assign sts.train = (item_q.mode == rnot_pkg::MODE_TRAIN);
	assign rsp_data  = rsp_q;

	// Working registers and output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req_data;
			acc_q  <= {{10{bias_q[23]}}, bias_q, 8'b0};
			clip_q <= 1'b0;
		end
		if (cmd.dot_mul || cmd.rate_mul || cmd.upd_mul) begin
			prod_q <= product[48:0];
		end
		if (cmd.acc_add) begin
			acc_q <= acc_q + prod_q[41:0];
		end
		if (cmd.rnd) begin
			if (pred_neg) begin
				pred_q <= '0;
			end else if (pred_ovf) begin
				pred_q <= 15'h7FFF;
			end else begin
				pred_q <= rval[14:0];
			end
			clip_q <= pred_ovf;
		end
		if (cmd.bias_upd) begin
			re_q   <= prod_q[32:0];
			clip_q <= clip_q | ovf_w(bias_sum);
		end
		if (cmd.upd_add) begin
			clip_q <= clip_q | ovf_w(w_sum);
		end
		if (cmd.out_load) begin
			rsp_q.prediction   <= pred_q;
			rsp_q.weight_a_now <= weight_q[0];
			rsp_q.weight_b_now <= (rnot_pkg::FEATURES > 1) ? weight_q[rnot_pkg::WB_IDX] : '0;
			rsp_q.bias_now     <= bias_q;
			rsp_q.clipped      <= clip_q;
		end
	end

	// Neuron state: training updates and reload from the init registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rnot_pkg::FEATURES; i++) begin
				weight_q[i] <= '0;
			end
			bias_q <= '0;
		end else begin
			if (cmd.rnd && item_q.mode == rnot_pkg::MODE_RELOAD) begin
				for (int i = 0; i < rnot_pkg::FEATURES; i++) begin
					if (i == 0) begin
						weight_q[i] <= cfg.init_weight_a;
					end else if (i == 1) begin
						weight_q[i] <= cfg.init_weight_b;
					end else begin
						weight_q[i] <= '0;
					end
				end
				bias_q <= cfg.init_bias;
			end
			if (cmd.bias_upd) begin
				bias_q <= sat_w(bias_sum);
			end
			if (cmd.upd_add) begin
				weight_q[cmd.idx] <= sat_w(w_sum);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/relu_neuron_online_trainer.sv
// One ReLU neuron with online delta-rule training. Each request gives a
// prediction, ReLU(sum of weight*feature + bias), from the weights held
// before the request. Mode 1 then moves every weight by rate*error*feature
// and the bias by rate*error (error = goal - prediction), mode 2 loads the
// weights and bias from the init registers, modes 0 and 3 only predict.
// All work runs through one shared 33x24 signed multiplier under a small
// sequencer, one request at a time: a request is accepted only in the idle
// state, to which the sequencer returns once the previous request has been
// worked through and its result has moved into the output register. A
// finished result waits there, so the next request is taken while it is
// still pending. Reset sets learn_rate to 66, the init registers to zero
// and the weights and bias to zero.
`default_nettype none

module relu_neuron_online_trainer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  rnot_pkg::req_t              req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output rnot_pkg::rsp_t              rsp_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rnot_pkg::ADDR_W-1:0] paddr,
	input  logic [rnot_pkg::DATA_W-1:0] pwdata,
	output logic [rnot_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	rnot_pkg::cfg_t cfg;
	rnot_pkg::cmd_t cmd;
	rnot_pkg::sts_t sts;

	rnot_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rnot_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rnot_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req_data),
		.cfg      (cfg),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_data (rsp_data)
	);

endmodule

`default_nettype wire

### rtl/core/rnot_check.sv
// Port-level checker for the neuron trainer and its bind to the top level.
// Depends on rnot_pkg for the payload types.
`default_nettype none

module rnot_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input rnot_pkg::rsp_t              rsp_data,
	input logic                        pready
);

	// A stalled result holds its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed or dropped while stalled");

	// Configuration port never inserts wait states
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

	// One request at a time: no acceptance right after an acceptance
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one still in work");

	// A new result only ever follows work in progress
	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared without a request in work");

endmodule

bind relu_neuron_online_trainer rnot_check u_check (.*);

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for relu_neuron_online_trainer: drives requests and APB register
// writes, predicts every response in fixed point and compares it field by field.
// Depends on rnot_pkg and the relu_neuron_online_trainer RTL.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rnot_pkg::*;

	// Modes that the package leaves unnamed
	localparam logic [1:0] MODE_PREDICT = 2'd0;
	localparam logic [1:0] MODE_SPARE   = 2'd3;

	localparam longint W_MAX = 64'sd8388607;
	localparam longint W_MIN = -64'sd8388608;
	localparam longint P_MAX = 64'sd32767;

	localparam int PHASE_ITEMS   = 435;
	localparam int SETTLE_CYCLES = 16;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	req_t              req_data  = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	rsp_t              rsp_data;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// Neuron state and register copies, as after reset
	longint wt_a          = 0;
	longint wt_b          = 0;
	longint bias_w        = 0;
	longint rate_cfg      = longint'(RATE_RESET);
	longint init_a_cfg    = 0;
	longint init_b_cfg    = 0;
	longint init_bias_cfg = 0;

	// Responses still owed by the block, oldest first
	rsp_t step_results_q[$];

	int send_idle_pct   = 0;
	int rsp_stall_pct   = 0;
	int mismatch_count  = 0;
	int results_checked = 0;
	int clip_seen       = 0;
	int train_sent      = 0;
	int predict_sent    = 0;
	int reload_sent     = 0;
	int spare_sent      = 0;

	relu_neuron_online_trainer uut (.*);

	always #1 clk = ~clk;

	// Round to nearest, ties toward plus infinity
	function automatic longint round_shift(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint sat_weight(input longint v);
		return (v > W_MAX) ? W_MAX : ((v < W_MIN) ? W_MIN : v);
	endfunction

	// One request through the neuron: prediction from the current weights, then update
	function automatic rsp_t neuron_step(input req_t r);
		longint sa, sb, acc, pred, err, nxt;
		logic   clip;
		rsp_t   res;
		sa   = $signed(r.sample_a);
		sb   = $signed(r.sample_b);
		clip = 1'b0;
		acc  = wt_a * sa + wt_b * sb + bias_w * 256;
		pred = round_shift(acc, 16);
		if (pred < 0) pred = 0;
		if (pred > P_MAX) begin
			pred = P_MAX;
			clip = 1'b1;
		end
		if (r.mode == MODE_TRAIN) begin
			// delta rule, no ReLU derivative
			err  = $signed(r.goal);
			err  = err - pred;
			nxt  = wt_a + round_shift(rate_cfg * err * sa, 16);
			wt_a = sat_weight(nxt);
			clip |= (wt_a != nxt);
			nxt  = wt_b + round_shift(rate_cfg * err * sb, 16);
			wt_b = sat_weight(nxt);
			clip |= (wt_b != nxt);
			nxt    = bias_w + round_shift(rate_cfg * err, 8);
			bias_w = sat_weight(nxt);
			clip |= (bias_w != nxt);
		end else if (r.mode == MODE_RELOAD) begin
			wt_a   = init_a_cfg;
			wt_b   = init_b_cfg;
			bias_w = init_bias_cfg;
		end
		res.prediction   = pred[14:0];
		res.weight_a_now = wt_a[23:0];
		res.weight_b_now = wt_b[23:0];
		res.bias_now     = bias_w[23:0];
		res.clipped      = clip;
		return res;
	endfunction

	function automatic req_t make_req(input logic [1:0] mode, input logic [15:0] a,
			input logic [15:0] b, input logic [15:0] g);
		req_t r;
		r.mode     = mode;
		r.sample_a = a;
		r.sample_b = b;
		r.goal     = g;
		return r;
	endfunction

	// Q7.8 value: corners now and then, some full range, mostly within +-4.0
	function automatic logic [15:0] rand_sample();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) begin
			case ($urandom_range(3))
				0: return 16'h7fff;
				1: return 16'h8000;
				2: return 16'h0000;
				default: return 16'hffff;
			endcase
		end
		if (pick < 4) return 16'($urandom);
		return 16'($urandom_range(2047)) - 16'd1024;
	endfunction

	// Q7.16 weight: full range or within +-2.0
	function automatic logic [23:0] rand_weight(input bit wide);
		if (wide) return 24'($urandom);
		return 24'($urandom_range(262143)) - 24'd131072;
	endfunction

	function automatic req_t any_req();
		return make_req(2'($urandom_range(3)), 16'($urandom), 16'($urandom), 16'($urandom));
	endfunction

	function automatic void check_field(input string fname, input logic [23:0] want,
			input logic [23:0] got);
		if (got !== want) begin
			$display("%0t ns: %s differs, expected %h, got %h", $time, fname, want, got);
			mismatch_count++;
		end
	endfunction

	// Send one request; idle gaps carry random data on the bus
	task automatic send_req(input req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			req_data  <= any_req();
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (!req_ready);
		step_results_q.push_back(neuron_step(r));
		case (r.mode)
			MODE_TRAIN:  train_sent++;
			MODE_RELOAD: reload_sent++;
			MODE_SPARE:  spare_sent++;
			default:     predict_sent++;
		endcase
	endtask

	// Drop valid and wait for every owed response
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (step_results_q.size() != 0) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_RATE:      rate_cfg      = longint'(value[15:0]);
			REG_INIT_A:    init_a_cfg    = longint'($signed(value[23:0]));
			REG_INIT_B:    init_b_cfg    = longint'($signed(value[23:0]));
			REG_INIT_BIAS: init_bias_cfg = longint'($signed(value[23:0]));
			default: ;
		endcase
	endtask

	task automatic set_neuron_config(input logic [15:0] rate, input logic [23:0] a,
			input logic [23:0] b, input logic [23:0] bias);
		write_reg(REG_RATE, DATA_W'(rate));
		write_reg(REG_INIT_A, {{8{a[23]}}, a});
		write_reg(REG_INIT_B, {{8{b[23]}}, b});
		write_reg(REG_INIT_BIAS, {{8{bias[23]}}, bias});
	endtask

	// Zero weights and the reset learning rate
	task automatic test_reset_state();
		send_req(make_req(MODE_PREDICT, 16'h7fff, 16'h8000, 16'h7fff));
		send_req(make_req(MODE_SPARE, 16'hffff, 16'h0001, 16'h0064));
		send_req(make_req(MODE_TRAIN, 16'h7fff, 16'h8000, 16'h7fff));
		send_req(make_req(MODE_TRAIN, 16'h0100, 16'hff00, 16'h8000));
		send_req(make_req(MODE_PREDICT, 16'h0100, 16'h0100, 16'h0000));
		wait_idle();
	endtask

	// Weights, bias and prediction driven into both rails
	task automatic test_saturation();
		set_neuron_config(16'hffff, 24'h7fffff, 24'h7fffff, 24'h7fffff);
		send_req(make_req(MODE_RELOAD, 16'h0000, 16'h0000, 16'h0000));
		send_req(make_req(MODE_PREDICT, 16'h7fff, 16'h7fff, 16'h0000));
		send_req(make_req(MODE_PREDICT, 16'h8000, 16'h8000, 16'h0000));
		send_req(make_req(MODE_SPARE, 16'h7fff, 16'h0000, 16'h0000));
		wait_idle();
		set_neuron_config(16'hffff, 24'h800000, 24'h800000, 24'h800000);
		// reload predicts with the old, maximal weights
		send_req(make_req(MODE_RELOAD, 16'h7fff, 16'h7fff, 16'h0000));
		send_req(make_req(MODE_PREDICT, 16'h8000, 16'h8000, 16'h0000));
		send_req(make_req(MODE_TRAIN, 16'h7fff, 16'h7fff, 16'h8000));
		send_req(make_req(MODE_TRAIN, 16'h8000, 16'h8000, 16'h7fff));
		send_req(make_req(MODE_TRAIN, 16'h8000, 16'h7fff, 16'h7fff));
		wait_idle();
	endtask

	// Moderate rate and weights: ordinary learning without clipping
	task automatic test_small_learning();
		set_neuron_config(16'd4096, 24'h010000, 24'hff8000, 24'h004000);
		send_req(make_req(MODE_RELOAD, 16'h0100, 16'h0100, 16'h0000));
		send_req(make_req(MODE_TRAIN, 16'h0100, 16'h0200, 16'h0180));
		send_req(make_req(MODE_TRAIN, 16'hff00, 16'h0080, 16'h0040));
		send_req(make_req(MODE_TRAIN, 16'h0300, 16'hfe00, 16'h0400));
		send_req(make_req(MODE_PREDICT, 16'h0100, 16'h0100, 16'h0000));
		send_req(make_req(MODE_TRAIN, 16'h0000, 16'h0000, 16'hff00));
		wait_idle();
	endtask

	// Mostly learning episodes (reload, then a run of training), rest any request
	task automatic test_random_stream(input int n_items, input int idle_pct,
			input int stall_pct);
		int          sent;
		logic [15:0] a, b, g;
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(3) != 0) begin
				send_req(make_req(MODE_RELOAD, rand_sample(), rand_sample(), rand_sample()));
				sent++;
				repeat ($urandom_range(30, 4)) begin
					a = rand_sample();
					b = rand_sample();
					// half the targets follow a/2 + b/4 so the weights can settle
					g = $urandom_range(1) ? 16'($signed(a) >>> 1) + 16'($signed(b) >>> 2)
						: rand_sample();
					if ($urandom_range(9) == 0) send_req(make_req(MODE_PREDICT, a, b, g));
					else send_req(make_req(MODE_TRAIN, a, b, g));
					sent++;
				end
			end else begin
				repeat ($urandom_range(8, 1)) begin
					send_req(any_req());
					sent++;
				end
			end
		end
		wait_idle();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
	endtask

	// Response side back-pressure
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// Compare each accepted response with the oldest owed one
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (step_results_q.size() == 0) begin
				$display("%0t ns: response with no request owed, expected none, got %h",
					$time, rsp_data);
				mismatch_count++;
			end else begin
				want = step_results_q.pop_front();
				results_checked++;
				if (want.clipped) clip_seen++;
				check_field("prediction", 24'(want.prediction), 24'(rsp_data.prediction));
				check_field("weight_a_now", want.weight_a_now, rsp_data.weight_a_now);
				check_field("weight_b_now", want.weight_b_now, rsp_data.weight_b_now);
				check_field("bias_now", want.bias_now, rsp_data.bias_now);
				check_field("clipped", 24'(want.clipped), 24'(rsp_data.clipped));
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_saturation();
		test_small_learning();
		set_neuron_config(16'd66, rand_weight(0), rand_weight(0), rand_weight(0));
		test_random_stream(PHASE_ITEMS, 0, 0);
		set_neuron_config(16'd0, rand_weight(1), rand_weight(1), rand_weight(1));
		test_random_stream(PHASE_ITEMS, 69, 0);
		set_neuron_config(16'($urandom_range(4095, 1)), rand_weight(0), rand_weight(0),
			rand_weight(0));
		test_random_stream(PHASE_ITEMS, 0, 69);
		set_neuron_config(16'($urandom), 24'h800000, 24'h7fffff, rand_weight(1));
		test_random_stream(PHASE_ITEMS, 37, 37);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d requests: %0d train, %0d predict, %0d reload, %0d spare mode.",
			train_sent + predict_sent + reload_sent + spare_sent, train_sent, predict_sent,
			reload_sent, spare_sent);
		$display("Checked %0d responses, %0d of them saturated, over 4 idle/stall phases.",
			results_checked, clip_seen);
		if (mismatch_count == 0) begin
			$display("relu_neuron_online_trainer: match");
		end else begin
			$display("relu_neuron_online_trainer: mismatch");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#500000;
		$display("Timed out with %0d responses still owed", step_results_q.size());
		$display("relu_neuron_online_trainer: mismatch");
		$finish;
	end

endmodule

### files.f
rtl/core/rnot_pkg.sv
rtl/core/rnot_regs.sv
rtl/core/rnot_ctrl.sv
rtl/core/rnot_dp.sv
rtl/core/relu_neuron_online_trainer.sv
rtl/core/rnot_check.sv
verif/tb_top.sv
